/* hw/rtl/trimmed_mean_ph_filter_macros.svh */
// Assertion macros for the filter RTL.
// TMF_ASSERT checks a property on the rising edge of clk while reset is released.
// TMF_ASSERT_ALWAYS checks a property on every rising edge of clk, reset included.
`ifndef TRIMMED_MEAN_PH_FILTER_MACROS_SVH
`define TRIMMED_MEAN_PH_FILTER_MACROS_SVH

`ifndef SYNTHESIS
`define TMF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TMF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TMF_ASSERT(label, prop, msg)
`define TMF_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* hw/rtl/tmf_pkg.sv */
package tmf_pkg;

  localparam int WINDOW_DEF      = 10;
  localparam int TRIM_DEF        = 2;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int OUT_BITS  = 15;
  localparam int GAIN_BITS = 16;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd8123;
  localparam logic [OUT_BITS-1:0]  OUT_MAX    = 15'h7FFF;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_RANK,
    ST_HAND
  } tmf_state_t;

endpackage

/* hw/rtl/tmf_in_if.sv */
interface tmf_in_if #(
  parameter int SAMPLE_W = tmf_pkg::SAMPLE_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* hw/rtl/tmf_out_if.sv */
interface tmf_out_if ();
  logic                         valid;
  logic                         ready;
  logic [tmf_pkg::OUT_BITS-1:0] trimmed_sum;
  logic [tmf_pkg::OUT_BITS-1:0] ph_q8;

  modport source (output valid, output trimmed_sum, output ph_q8, input ready);
  modport sink   (input valid, input trimmed_sum, input ph_q8, output ready);
endinterface

/* hw/rtl/tmf_window_ram.sv */
module tmf_window_ram #(
  parameter int DEPTH  = tmf_pkg::WINDOW_DEF,
  parameter int DATA_W = tmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata_r
);

  logic [DATA_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

/* hw/rtl/tmf_rank_unit.sv */
`include "trimmed_mean_ph_filter_macros.svh"

module tmf_rank_unit #(
  parameter int WINDOW      = tmf_pkg::WINDOW_DEF,
  parameter int TRIM        = tmf_pkg::TRIM_DEF,
  parameter int SAMPLE_BITS = tmf_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   sum_valid,
  input  logic                   sum_ready,
  output logic [SUM_W-1:0]       sum
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int K_W   = $clog2(WINDOW + 2);

  localparam logic [IDX_W:0]   TRIM_LO  = (IDX_W + 1)'(TRIM);
  localparam logic [IDX_W:0]   TRIM_HI  = (IDX_W + 1)'(WINDOW - TRIM);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
  localparam logic [K_W-1:0]   K_LAST   = K_W'(WINDOW);

  tmf_pkg::tmf_state_t state_r, state_nxt;

  logic [IDX_W-1:0]       fill_r, fill_nxt;
  logic [IDX_W-1:0]       piv_idx_r, piv_idx_nxt;
  logic [K_W-1:0]         k_r, k_nxt;
  logic [K_W-1:0]         kd_r;
  logic                   rd_v_r;
  logic [SAMPLE_BITS-1:0] pivot_r, pivot_nxt;
  logic [IDX_W-1:0]       rank_r, rank_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;

  logic                   accept;
  logic                   issue;
  logic [IDX_W-1:0]       raddr;
  logic [SAMPLE_BITS-1:0] rdata;
  logic [IDX_W-1:0]       cmp_j;
  logic                   is_less;
  logic [IDX_W-1:0]       rank_cnt;
  logic                   last_cmp;
  logic                   keep;

  assign in_ready  = (state_r == tmf_pkg::ST_FILL);
  assign accept    = in_valid && in_ready;
  assign sum_valid = (state_r == tmf_pkg::ST_HAND);
  assign sum       = sum_r;

  // One read per cycle: first the pivot itself, then every entry of the window.
  assign issue = (state_r == tmf_pkg::ST_RANK) && (k_r <= K_LAST);
  assign raddr = (k_r == '0) ? piv_idx_r : IDX_W'(k_r - 1'b1);

  tmf_window_ram #(
    .DEPTH  (WINDOW),
    .DATA_W (SAMPLE_BITS)
  ) u_ram (
    .clk     (clk),
    .we      (accept),
    .waddr   (fill_r),
    .wdata   (in_sample),
    .re      (issue),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  // Ties are broken by position, so the ranks form a permutation of the window.
  assign cmp_j    = IDX_W'(kd_r - 1'b1);
  assign is_less  = rd_v_r && (kd_r != '0) &&
                    ((rdata < pivot_r) || ((rdata == pivot_r) && (cmp_j < piv_idx_r)));
  assign rank_cnt = rank_r + IDX_W'(is_less);
  assign last_cmp = rd_v_r && (kd_r == K_LAST);
  assign keep     = ({1'b0, rank_cnt} >= TRIM_LO) && ({1'b0, rank_cnt} < TRIM_HI);

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    piv_idx_nxt = piv_idx_r;
    k_nxt       = k_r;
    rank_nxt    = rank_r;
    sum_nxt     = sum_r;
    pivot_nxt   = pivot_r;

    if (rd_v_r && (kd_r == '0)) begin
      pivot_nxt = rdata;
    end

    case (state_r)
      tmf_pkg::ST_FILL: begin
        if (accept) begin
          if (fill_r == LAST_IDX) begin
            fill_nxt    = '0;
            piv_idx_nxt = '0;
            k_nxt       = '0;
            rank_nxt    = '0;
            sum_nxt     = '0;
            state_nxt   = tmf_pkg::ST_RANK;
          end else begin
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      tmf_pkg::ST_RANK: begin
        if (issue) begin
          k_nxt = k_r + 1'b1;
        end
        if (last_cmp) begin
          if (keep) begin
            sum_nxt = sum_r + SUM_W'(pivot_r);
          end
          rank_nxt = '0;
          k_nxt    = '0;
          if (piv_idx_r == LAST_IDX) begin
            state_nxt = tmf_pkg::ST_HAND;
          end else begin
            piv_idx_nxt = piv_idx_r + 1'b1;
          end
        end else begin
          rank_nxt = rank_cnt;
        end
      end
      tmf_pkg::ST_HAND: begin
        if (sum_ready) begin
          state_nxt = tmf_pkg::ST_FILL;
        end
      end
      default: begin
        state_nxt = tmf_pkg::ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tmf_pkg::ST_FILL;
      fill_r    <= '0;
      piv_idx_r <= '0;
      k_r       <= '0;
      kd_r      <= '0;
      rd_v_r    <= 1'b0;
      rank_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      piv_idx_r <= piv_idx_nxt;
      k_r       <= k_nxt;
      kd_r      <= k_r;
      rd_v_r    <= issue;
      rank_r    <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pivot_r <= pivot_nxt;
    sum_r   <= sum_nxt;
  end

  `TMF_ASSERT(a_no_write_in_rank, !(accept && (issue || rd_v_r)), "store written during ranking")
  `TMF_ASSERT(a_rank_start, (accept && (fill_r == LAST_IDX)) |=> ((state_r == tmf_pkg::ST_RANK) && (k_r == '0) && (sum_r == '0)), "ranking pass did not start cleanly")
  `TMF_ASSERT(a_rank_bound, (state_r == tmf_pkg::ST_RANK) |-> (rank_r <= LAST_IDX), "rank count beyond window")
  `TMF_ASSERT(a_sum_hold, (sum_valid && !sum_ready) |=> (sum_valid && $stable(sum_r)), "trimmed sum changed before handoff")

endmodule

/* hw/rtl/tmf_scale_out.sv */
module tmf_scale_out #(
  parameter int SUM_W = tmf_pkg::SAMPLE_BITS_DEF + $clog2(tmf_pkg::WINDOW_DEF + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          sum_valid,
  output logic                          sum_ready,
  input  logic [SUM_W-1:0]              sum,
  input  logic [tmf_pkg::GAIN_BITS-1:0] gain,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tmf_pkg::OUT_BITS-1:0]  out_trimmed_sum,
  output logic [tmf_pkg::OUT_BITS-1:0]  out_ph_q8
);

  localparam int PROD_W    = SUM_W + tmf_pkg::GAIN_BITS;
  localparam int SUM_EXT_W = (SUM_W > tmf_pkg::OUT_BITS) ? SUM_W : tmf_pkg::OUT_BITS + 1;
  localparam logic [SUM_EXT_W-1:0] MAX_EXT = SUM_EXT_W'(tmf_pkg::OUT_MAX);

  logic                         s1_v_r, s2_v_r, out_v_r;
  logic [SUM_W-1:0]             s1_sum_r, s2_sum_r;
  logic [PROD_W-1:0]            prod_r;
  logic [tmf_pkg::OUT_BITS-1:0] out_sum_r, out_ph_r;

  logic [SUM_EXT_W-1:0]         sum_ext, ph_ext;
  logic [tmf_pkg::OUT_BITS-1:0] sum_sat, ph_sat;

  // One result in flight at a time; a window takes far longer than this pipeline.
  assign sum_ready = !(s1_v_r || s2_v_r || out_v_r);

  assign sum_ext = SUM_EXT_W'(s2_sum_r);
  assign ph_ext  = SUM_EXT_W'(prod_r >> tmf_pkg::GAIN_BITS);
  assign sum_sat = (sum_ext > MAX_EXT) ? tmf_pkg::OUT_MAX : sum_ext[tmf_pkg::OUT_BITS-1:0];
  assign ph_sat  = (ph_ext > MAX_EXT) ? tmf_pkg::OUT_MAX : ph_ext[tmf_pkg::OUT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r <= sum_valid && sum_ready;
      s2_v_r <= s1_v_r;
      if (s2_v_r) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid && sum_ready) begin
      s1_sum_r <= sum;
    end
    if (s1_v_r) begin
      s2_sum_r <= s1_sum_r;
      prod_r   <= PROD_W'(s1_sum_r) * PROD_W'(gain);
    end
    if (s2_v_r) begin
      out_sum_r <= sum_sat;
      out_ph_r  <= ph_sat;
    end
  end

  assign out_valid       = out_v_r;
  assign out_trimmed_sum = out_sum_r;
  assign out_ph_q8       = out_ph_r;

endmodule

/* hw/rtl/trimmed_mean_ph_filter.sv */
// Channel   Direction  Word
// in_ch     sink       sample (SAMPLE_BITS bits)
// out_ch    source     trimmed_sum (15 bits), ph_q8 (15 bits)
// cfg       write      gain_q16 (16 bits)
//
// Samples are taken while the window fills; after the last sample of a window the ranking
// pass reads the window store through its single read port, the pivot and then the whole
// window for each entry in turn, then scaling stages s1, s2 and out register the result.
// Reset clears the control state and loads the default gain; the store needs no clearing.
// Input is refused during ranking and handoff, and handoff waits while a word sits on out_ch.
module trimmed_mean_ph_filter #(
  parameter int WINDOW      = tmf_pkg::WINDOW_DEF,
  parameter int TRIM        = tmf_pkg::TRIM_DEF,
  parameter int SAMPLE_BITS = tmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tmf_in_if.sink                        in_ch,
  tmf_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [tmf_pkg::GAIN_BITS-1:0] cfg_wdata
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW + 1);

  logic [tmf_pkg::GAIN_BITS-1:0] gain_r;
  logic                          sum_valid;
  logic                          sum_ready;
  logic [SUM_W-1:0]              sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= tmf_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      gain_r <= cfg_wdata;
    end
  end

  tmf_rank_unit #(
    .WINDOW      (WINDOW),
    .TRIM        (TRIM),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_sample (in_ch.sample),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum)
  );

  tmf_scale_out #(
    .SUM_W (SUM_W)
  ) u_scale (
    .clk             (clk),
    .rst_n           (rst_n),
    .sum_valid       (sum_valid),
    .sum_ready       (sum_ready),
    .sum             (sum),
    .gain            (gain_r),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_trimmed_sum (out_ch.trimmed_sum),
    .out_ph_q8       (out_ch.ph_q8)
  );

endmodule
